[rtl/core/pis_pkg.sv]
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and register indexes for the PID controller with integral
// separation.
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SUM_LIMIT   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DRIVE_LIMIT = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SEP_GAP     = 3'd5;

    localparam logic [30:0] SumLimitReset   = 31'h7FFF_FFFF;
    localparam logic [14:0] DriveLimitReset = 15'h7FFF;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] feedback;
    } t_in;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               integrating;
        logic               clipped;
    } t_out;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [30:0]        sum_limit;
        logic [14:0]        drive_limit;
        logic [16:0]        separation_gap;
    } t_cfg;

    // Error stage result: operands for the three gain multiplies.
    typedef struct packed {
        logic signed [16:0] err;
        logic signed [17:0] diff;
        logic signed [31:0] sum;
        logic               in_gap;
    } t_err;

    // Multiply stage result: each product already shifted right by 8 (floor).
    typedef struct packed {
        logic signed [24:0] pterm;
        logic signed [39:0] iterm;
        logic signed [25:0] dterm;
        logic               in_gap;
    } t_terms;

endpackage

[rtl/core/pid_integral_separation.sv]
// ----------------------------------------------------------------------------
// pid_integral_separation
// Positional PID controller with integral separation, fixed point.
// ----------------------------------------------------------------------------
// Each transfer on the input channel produces exactly one result transfer,
// passing through the input register, error stage, multiply stage and output
// register. A new item is taken every cycle while the output side does not
// stall; the error sum and previous error are updated in the error stage as
// each item passes, so consecutive items chain without gaps.
// Each stage holds its item while the stage after it is full and stalled,
// so the input keeps accepting until all four registers are occupied.
// Configuration writes are always accepted and must be made while no item
// is in flight.
module pid_integral_separation
    import pis_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg   w_cfg;
    logic   r_in_valid;
    t_in    r_in_data;
    logic   w_in_load;
    logic   w_err_ready;
    logic   w_err_valid;
    t_err   w_err_data;
    logic   w_mul_ready;
    logic   w_mul_valid;
    t_terms w_mul_data;
    logic   w_mix_ready;

    assign o_cfg_ready = 1'b1;

    pis_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_in_load  = !r_in_valid || w_err_ready;
    assign o_in_ready = w_in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    pis_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (r_in_valid),
        .o_ready (w_err_ready),
        .i_data  (r_in_data),
        .o_valid (w_err_valid),
        .i_ready (w_mul_ready),
        .o_data  (w_err_data)
    );

    pis_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_err_valid),
        .o_ready (w_mul_ready),
        .i_data  (w_err_data),
        .o_valid (w_mul_valid),
        .i_ready (w_mix_ready),
        .o_data  (w_mul_data)
    );

    pis_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_mul_valid),
        .o_ready (w_mix_ready),
        .i_data  (w_mul_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[rtl/core/pis_cfg.sv]
// ----------------------------------------------------------------------------
// pis_cfg
// Configuration register file: gains, clamp limits and separation gap.
// ----------------------------------------------------------------------------
module pis_cfg
    import pis_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  logic [CfgIdxW-1:0]  i_index,
    input  logic [CfgDataW-1:0] i_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.sum_limit      <= SumLimitReset;
            r_cfg.drive_limit    <= DriveLimitReset;
            r_cfg.separation_gap <= '0;
        end else if (i_wr) begin
            case (i_index)
                CFG_GAIN_P:      r_cfg.gain_p         <= i_data[15:0];
                CFG_GAIN_I:      r_cfg.gain_i         <= i_data[15:0];
                CFG_GAIN_D:      r_cfg.gain_d         <= i_data[15:0];
                CFG_SUM_LIMIT:   r_cfg.sum_limit      <= i_data[30:0];
                CFG_DRIVE_LIMIT: r_cfg.drive_limit    <= i_data[14:0];
                CFG_SEP_GAP:     r_cfg.separation_gap <= i_data[16:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pis_err.sv]
// ----------------------------------------------------------------------------
// pis_err
// Error stage: forms the error and its difference, and updates the error sum
// (clamped, cleared outside the separation gap) and previous error per item.
// ----------------------------------------------------------------------------
module pis_err
    import pis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_err o_data
);

    logic               r_valid;
    t_err               r_data;
    logic signed [16:0] r_prev;
    logic signed [31:0] r_sum;

    logic               w_load;
    logic signed [16:0] w_err;
    logic [16:0]        w_mag;
    logic               w_inside;
    logic signed [32:0] w_acc;
    logic signed [31:0] w_sat;
    logic signed [31:0] w_lim;
    logic signed [31:0] w_clamp;
    logic signed [31:0] n_sum;
    logic signed [17:0] w_diff;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    always_comb begin
        w_err    = {i_data.setpoint[15], i_data.setpoint}
                 - {i_data.feedback[15], i_data.feedback};
        w_mag    = w_err[16] ? 17'(-w_err) : w_err;
        w_inside = w_mag < i_cfg.separation_gap;
        w_acc    = {r_sum[31], r_sum} + {{16{w_err[16]}}, w_err};
        // Saturate to 32 bits before the programmable clamp.
        if (w_acc[32] != w_acc[31]) begin
            w_sat = w_acc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_sat = w_acc[31:0];
        end
        w_lim = {1'b0, i_cfg.sum_limit};
        if (w_sat > w_lim) begin
            w_clamp = w_lim;
        end else if (w_sat < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_sat;
        end
        n_sum  = w_inside ? w_clamp : '0;
        w_diff = {w_err[16], w_err} - {r_prev[16], r_prev};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
            r_sum   <= '0;
        end else if (w_load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_prev <= w_err;
                r_sum  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_data.err    <= w_err;
            r_data.diff   <= w_diff;
            r_data.sum    <= n_sum;
            r_data.in_gap <= w_inside;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/core/pis_mul.sv]
// ----------------------------------------------------------------------------
// pis_mul
// Multiply stage: the three Q8.8 gain products, each scaled back by 8 bits.
// ----------------------------------------------------------------------------
module pis_mul
    import pis_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_err   i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_terms o_data
);

    logic               r_valid;
    t_terms             r_data;
    logic               w_load;
    logic signed [32:0] w_p;
    logic signed [47:0] w_i;
    logic signed [33:0] w_d;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    always_comb begin
        w_p = i_cfg.gain_p * i_data.err;
        w_i = i_cfg.gain_i * i_data.sum;
        w_d = i_cfg.gain_d * i_data.diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // Dropping the low 8 bits of a two's complement product rounds toward
    // minus infinity.
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_data.pterm  <= w_p[32:8];
            r_data.iterm  <= w_i[47:8];
            r_data.dterm  <= w_d[33:8];
            r_data.in_gap <= i_data.in_gap;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/core/pis_mix.sv]
// ----------------------------------------------------------------------------
// pis_mix
// Output stage: adds the three terms and clamps the total to the drive limit.
// ----------------------------------------------------------------------------
module pis_mix
    import pis_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_terms i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    logic               r_valid;
    t_out               r_data;
    logic               w_load;
    logic signed [40:0] w_total;
    logic signed [40:0] w_lim;
    logic signed [40:0] w_clamp;
    logic               w_hit;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    always_comb begin
        w_total = {{16{i_data.pterm[24]}}, i_data.pterm}
                + {i_data.iterm[39], i_data.iterm}
                + {{15{i_data.dterm[25]}}, i_data.dterm};
        w_lim   = {26'd0, i_cfg.drive_limit};
        if (w_total > w_lim) begin
            w_clamp = w_lim;
            w_hit   = 1'b1;
        end else if (w_total < -w_lim) begin
            w_clamp = -w_lim;
            w_hit   = 1'b1;
        end else begin
            w_clamp = w_total;
            w_hit   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_data.drive       <= w_clamp[15:0];
            r_data.integrating <= i_data.in_gap;
            r_data.clipped     <= w_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
